// ----- sv/texel_format_to_rgba8_unit_defines.svh -----
// Assertion macros used by the checker file tfr_checker.sv.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TEXEL_FORMAT_TO_RGBA8_UNIT_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8_UNIT_DEFINES_SVH

// An expression that must hold at every clock edge outside reset.
`define TFR_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// An antecedent that implies a consequent, which may be a delayed sequence.
`define TFR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/tfr_pkg.sv -----
`timescale 1ns / 1ps

package tfr_pkg;

	typedef enum logic [3:0] {
		LAYOUT_A8       = 4'd0,
		LAYOUT_ARGB4444 = 4'd1,
		LAYOUT_RGB24    = 4'd2,
		LAYOUT_RGBA32   = 4'd3,
		LAYOUT_ARGB32   = 4'd4,
		LAYOUT_RGB565   = 4'd5,
		LAYOUT_R16      = 4'd6,
		LAYOUT_RGBA4444 = 4'd7,
		LAYOUT_BGRA32   = 4'd8,
		LAYOUT_RG16     = 4'd9,
		LAYOUT_R8       = 4'd10
	} layout_t;

	localparam layout_t LAYOUT_RESET = LAYOUT_RGB24;
	localparam logic [7:0] CHAN_MAX = 8'hFF;
	localparam logic [7:0] CHAN_ZERO = 8'h00;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// v*255/31 truncated, written as 8*v plus floor(7*v/31).
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [2:0] corr;
		begin
			if (v == 5'd31) begin
				corr = 3'd7;
			end else if (v >= 5'd27) begin
				corr = 3'd6;
			end else if (v >= 5'd23) begin
				corr = 3'd5;
			end else if (v >= 5'd18) begin
				corr = 3'd4;
			end else if (v >= 5'd14) begin
				corr = 3'd3;
			end else if (v >= 5'd9) begin
				corr = 3'd2;
			end else if (v >= 5'd5) begin
				corr = 3'd1;
			end else begin
				corr = 3'd0;
			end
			widen5 = {v, 3'b000} + {5'd0, corr};
		end
	endfunction

	// v*255/63 truncated, written as 4*v plus floor(v/21).
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [1:0] corr;
		begin
			if (v == 6'd63) begin
				corr = 2'd3;
			end else if (v >= 6'd42) begin
				corr = 2'd2;
			end else if (v >= 6'd21) begin
				corr = 2'd1;
			end else begin
				corr = 2'd0;
			end
			widen6 = {v, 2'b00} + {6'd0, corr};
		end
	endfunction

	// v*17 is the nibble repeated.
	function automatic logic [7:0] widen4(input logic [3:0] v);
		widen4 = {v, v};
	endfunction

endpackage

// ----- sv/tfr_convert.sv -----
`timescale 1ns / 1ps

module tfr_convert import tfr_pkg::*; (
	input  layout_t     layout,
	input  logic [31:0] texel_bytes,
	output rgba_t       pix
);

	logic [7:0] b0;
	logic [7:0] b1;
	logic [7:0] b2;
	logic [7:0] b3;
	logic [15:0] v;

	assign b0 = texel_bytes[7:0];
	assign b1 = texel_bytes[15:8];
	assign b2 = texel_bytes[23:16];
	assign b3 = texel_bytes[31:24];
	assign v = texel_bytes[15:0];

	always_comb begin
		pix.red = CHAN_ZERO;
		pix.green = CHAN_ZERO;
		pix.blue = CHAN_ZERO;
		pix.alpha = CHAN_MAX;
		unique case (layout)
			LAYOUT_A8: begin
				pix.red = CHAN_MAX;
				pix.green = CHAN_MAX;
				pix.blue = CHAN_MAX;
				pix.alpha = b0;
			end
			LAYOUT_ARGB4444: begin
				pix.red = widen4(v[11:8]);
				pix.green = widen4(v[7:4]);
				pix.blue = widen4(v[3:0]);
				pix.alpha = widen4(v[15:12]);
			end
			LAYOUT_RGB24: begin
				pix.red = b0;
				pix.green = b1;
				pix.blue = b2;
			end
			LAYOUT_RGBA32: begin
				pix.red = b0;
				pix.green = b1;
				pix.blue = b2;
				pix.alpha = b3;
			end
			LAYOUT_ARGB32: begin
				pix.alpha = b0;
				pix.red = b1;
				pix.green = b2;
				pix.blue = b3;
			end
			LAYOUT_RGB565: begin
				pix.red = widen5(v[15:11]);
				pix.green = widen6(v[10:5]);
				pix.blue = widen5(v[4:0]);
			end
			LAYOUT_R16: begin
				pix.red = b1;
			end
			LAYOUT_RGBA4444: begin
				pix.red = widen4(v[3:0]);
				pix.green = widen4(v[7:4]);
				pix.blue = widen4(v[11:8]);
				pix.alpha = widen4(v[15:12]);
			end
			LAYOUT_BGRA32: begin
				pix.blue = b0;
				pix.green = b1;
				pix.red = b2;
				pix.alpha = b3;
			end
			LAYOUT_RG16: begin
				pix.red = b0;
				pix.green = b1;
			end
			LAYOUT_R8: begin
				pix.red = b0;
			end
			default: begin
				pix.red = CHAN_ZERO;
			end
		endcase
	end

endmodule

// ----- sv/texel_format_to_rgba8_unit.sv -----
`timescale 1ns / 1ps

// Texel unpacker: turns one raw texel of up to four little-endian bytes into
// 8-bit red, green, blue and alpha.
// Input channel: a texel is taken at a rising edge where start is high and
// busy is low. Busy stays low, so a texel may be offered in every cycle.
// Result channel: done is high for one cycle with red, green, blue and alpha
// valid in that cycle. The receiver cannot stall, so no result is held back.
// From the accepting edge a texel passes one input register, then the format
// decode and channel widening, then the result register that drives done
// and the channels. Throughput is one texel per cycle.
// Configuration: the source layout is written through cfg_data when cfg_valid
// is high; cfg_ready is always high. Write it only while no texel is in flight.
// Reset clears the pipeline valid bits and sets the layout to RGB24.

module texel_format_to_rgba8_unit import tfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] texel_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);

	layout_t     source_layout_q;
	logic        valid_s1;
	logic [31:0] texel_s1;
	logic        valid_s2;
	rgba_t       pix;
	rgba_t       pix_s2;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_layout_q <= LAYOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			source_layout_q <= layout_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			texel_s1 <= texel_bytes;
		end
		if (valid_s1) begin
			pix_s2 <= pix;
		end
	end

	tfr_convert u_convert (
		.layout      (source_layout_q),
		.texel_bytes (texel_s1),
		.pix         (pix)
	);

	assign done = valid_s2;
	assign red = pix_s2.red;
	assign green = pix_s2.green;
	assign blue = pix_s2.blue;
	assign alpha = pix_s2.alpha;

endmodule

// ----- sv/tfr_checker.sv -----
`timescale 1ns / 1ps

`include "texel_format_to_rgba8_unit_defines.svh"

module tfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        done
);

	logic take;

	assign take = start && !busy;

	`TFR_ASSERT_ALWAYS(a_always_open, !busy && cfg_ready, "input or config channel blocked")

	`TFR_ASSERT_IMPLY(a_result_follows, take, ##2 done, "accepted texel gave no result")

	`TFR_ASSERT_IMPLY(a_no_spurious, done, $past(take, 2), "result without an accepted texel")

	`TFR_ASSERT_IMPLY(a_cfg_idle, cfg_valid && cfg_ready, !take && !$past(take) && !done, "config write with a texel in flight")

endmodule

bind texel_format_to_rgba8_unit tfr_checker u_tfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.done      (done)
);

// ----- verif/texel_unpack_checker.sv -----
`timescale 1ns / 1ps

module texel_unpack_checker import tfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] texel_bytes,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        done,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output int          fail_count,
	output int          outstanding
);

	logic [3:0] layout_q;
	rgba_t      pixel_q[$];

	function automatic logic [7:0] expand5(input logic [4:0] v);
		int w;
		w = int'(v) * 255 / 31;
		return w[7:0];
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		int w;
		w = int'(v) * 255 / 63;
		return w[7:0];
	endfunction

	function automatic logic [7:0] expand4(input logic [3:0] v);
		int w;
		w = int'(v) * 17;
		return w[7:0];
	endfunction

	function automatic rgba_t unpack_texel(input logic [3:0] fmt, input logic [31:0] t);
		rgba_t px;
		logic [15:0] h;
		h = t[15:0];
		px.red = CHAN_ZERO;
		px.green = CHAN_ZERO;
		px.blue = CHAN_ZERO;
		px.alpha = CHAN_MAX;
		case (fmt)
			LAYOUT_A8: begin
				px.red = CHAN_MAX;
				px.green = CHAN_MAX;
				px.blue = CHAN_MAX;
				px.alpha = t[7:0];
			end
			LAYOUT_ARGB4444: begin
				px.red = expand4(h[11:8]);
				px.green = expand4(h[7:4]);
				px.blue = expand4(h[3:0]);
				px.alpha = expand4(h[15:12]);
			end
			LAYOUT_RGB24: begin
				px.red = t[7:0];
				px.green = t[15:8];
				px.blue = t[23:16];
			end
			LAYOUT_RGBA32: begin
				px.red = t[7:0];
				px.green = t[15:8];
				px.blue = t[23:16];
				px.alpha = t[31:24];
			end
			LAYOUT_ARGB32: begin
				px.alpha = t[7:0];
				px.red = t[15:8];
				px.green = t[23:16];
				px.blue = t[31:24];
			end
			LAYOUT_RGB565: begin
				px.red = expand5(h[15:11]);
				px.green = expand6(h[10:5]);
				px.blue = expand5(h[4:0]);
			end
			LAYOUT_R16: begin
				px.red = t[15:8];
			end
			LAYOUT_RGBA4444: begin
				px.red = expand4(h[3:0]);
				px.green = expand4(h[7:4]);
				px.blue = expand4(h[11:8]);
				px.alpha = expand4(h[15:12]);
			end
			LAYOUT_BGRA32: begin
				px.blue = t[7:0];
				px.green = t[15:8];
				px.red = t[23:16];
				px.alpha = t[31:24];
			end
			LAYOUT_RG16: begin
				px.red = t[7:0];
				px.green = t[15:8];
			end
			LAYOUT_R8: begin
				px.red = t[7:0];
			end
			default: begin
			end
		endcase
		return px;
	endfunction

	initial begin
		fail_count = 0;
		outstanding = 0;
		layout_q = LAYOUT_RESET;
	end

	always @(posedge clk) begin
		rgba_t want;
		if (arst_n) begin
			if (done) begin
				if (pixel_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: result with no texel pending: r=%h g=%h b=%h a=%h",
							$realtime, red, green, blue, alpha);
					end
					fail_count++;
				end else begin
					want = pixel_q.pop_front();
					if (red !== want.red || green !== want.green ||
							blue !== want.blue || alpha !== want.alpha) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch: expected rgba %h %h %h %h,",
								$realtime, want.red, want.green, want.blue, want.alpha,
								" got %h %h %h %h", red, green, blue, alpha);
						end
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				pixel_q.insert(pixel_q.size(), unpack_texel(layout_q, texel_bytes));
			end
			if (cfg_valid && cfg_ready) begin
				layout_q = cfg_data;
			end
			outstanding = pixel_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import tfr_pkg::*; ();

	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] texel_bytes;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        done;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	int          fail_count;
	int          outstanding;
	int          burst_left;
	int          cycles;

	texel_format_to_rgba8_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.texel_bytes(texel_bytes),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha)
	);

	texel_unpack_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.texel_bytes(texel_bytes),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// Leaves start high on return within a burst, so that a following beat
	// can go out on the next edge; between bursts it may drop start for a gap.
	task automatic send_texel(input logic [31:0] t);
		int gap;
		start <= 1'b1;
		texel_bytes <= t;
		do @(posedge clk); while (busy);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(25, 60);
			end else begin
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic set_layout(input logic [3:0] fmt);
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= fmt;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_texel();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom & 32'h0000_FFFF;
			3: return $urandom | 32'hFFFF_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent;
		int run_len;
		logic [3:0] fmt;
		arst_n = 1'b0;
		start = 1'b0;
		texel_bytes = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		burst_left = 1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The layout after reset must already be in effect.
		send_texel(32'h0000_0000);
		send_texel(32'hFFFF_FFFF);

		for (int k = 0; k < 16; k++) begin
			set_layout(k[3:0]);
			send_texel(k[0] ? 32'hFFFF_FFFF : 32'hC4A3_7E15);
			if (k[3:0] == LAYOUT_RGB565) begin
				send_texel(32'h0000_F81F);
				send_texel(32'h0000_07E0);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				fmt = 4'($urandom_range(0, 15));
			end else begin
				fmt = 4'($urandom_range(0, 10));
			end
			set_layout(fmt);
			run_len = $urandom_range(8, 40);
			for (int n = 0; n < run_len; n++) begin
				send_texel(pick_texel());
				sent++;
			end
		end

		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
